// ===== hw/rtl/audio_ring_refill_controller_core_defines.svh =====
// Assertion macros for the ring refill controller.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef AUDIO_RING_REFILL_CONTROLLER_CORE_DEFINES_SVH
`define AUDIO_RING_REFILL_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define ARRC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ARRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/arrc_pkg.sv =====
// Shared types and codes for the audio ring refill controller.
// No dependencies.
package arrc_pkg;

  localparam logic [2:0] KIND_TICK      = 3'd0;
  localparam logic [2:0] KIND_ATTACH    = 3'd1;
  localparam logic [2:0] KIND_DETACH    = 3'd2;
  localparam logic [2:0] KIND_UPDATE    = 3'd3;
  localparam logic [2:0] KIND_FILL_DONE = 3'd4;

  localparam logic [1:0] MODE_FREE     = 2'd0;
  localparam logic [1:0] MODE_STARTED  = 2'd1;
  localparam logic [1:0] MODE_UPDATED  = 2'd2;
  localparam logic [1:0] MODE_ORPHANED = 2'd3;

  localparam int CURSOR_W = 15;

  typedef struct packed {
    logic [2:0]          kind;
    logic [CURSOR_W-1:0] play_cursor;
    logic [CURSOR_W-1:0] write_cursor;
    logic                buffer_lost;
    logic [CURSOR_W-1:0] bytes_read;
    logic                end_of_stream;
  } item_t;

  typedef struct packed {
    logic                fill_valid;
    logic [CURSOR_W-1:0] fill_offset;
    logic [CURSOR_W-1:0] fill_bytes;
    logic                cross_fade;
    logic                silence;
    logic                rewind;
    logic                stopped;
    logic [1:0]          source_state;
  } res_t;

endpackage

// ===== hw/rtl/arrc_cmod.sv =====
// Remainder of an unsigned value by a constant, restoring compare/subtract steps.
// Standalone; step count follows from input width and divisor.
module arrc_cmod #(
  parameter int IN_W    = 15,
  parameter int DIVISOR = 8192,
  parameter int REM_W   = 15
) (
  input  logic [IN_W-1:0]  num,
  output logic [REM_W-1:0] rem
);

  localparam longint MAX_Q = ((longint'(1) << IN_W) - 1) / DIVISOR;
  localparam int     STEPS = (MAX_Q > 0) ? $clog2(MAX_Q + 1) : 0;

  logic [IN_W-1:0] part;

  always_comb begin
    part = num;
    for (int i = STEPS - 1; i >= 0; i--) begin
      if (longint'(part) >= (longint'(DIVISOR) << i)) begin
        part = part - IN_W'(longint'(DIVISOR) << i);
      end
    end
    rem = REM_W'(part);
  end

endmodule

// ===== hw/rtl/arrc_step.sv =====
// Event engine: source state, ring marks and end range, plus the per-event result.
// Depends on arrc_pkg and arrc_cmod.
module arrc_step #(
  parameter int RING_BYTES  = 32768,
  parameter int CHUNK_BYTES = 8192
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           advance,
  input  arrc_pkg::item_t item,
  output arrc_pkg::res_t  result
);
  import arrc_pkg::*;

  localparam int MW        = $clog2(RING_BYTES);
  localparam int SW        = ((MW > CURSOR_W) ? MW : CURSOR_W) + 1;
  localparam int CHUNK_MOD = CHUNK_BYTES % RING_BYTES;
  localparam int TWO_CHUNK = 2 * CHUNK_BYTES;

  logic [1:0]    source_mode_r, source_mode_nxt;
  logic          resync_pending_r, resync_pending_nxt;
  logic [MW-1:0] valid_mark_r, valid_mark_nxt;
  logic [MW-1:0] trigger_mark_r, trigger_mark_nxt;
  logic [MW-1:0] next_write_mark_r, next_write_mark_nxt;
  logic [MW-1:0] latched_play_r, latched_play_nxt;
  logic [MW-1:0] last_fill_start_r, last_fill_start_nxt;
  logic          end_range_valid_r, end_range_valid_nxt;
  logic [MW-1:0] end_range_low_r, end_range_low_nxt;
  logic [MW-1:0] end_range_high_r, end_range_high_nxt;

  logic [MW-1:0]       play_m, wr_m;
  logic [CURSOR_W-1:0] wr15, chunk_rem;
  logic [MW-1:0]       base_mark, trig_new, next_new, end_high;
  logic [SW-1:0]       end_sum;

  logic          t_resync, t_data, t_erv;
  logic [1:0]    t_mode;
  logic [MW-1:0] t_off;

  function automatic logic [MW-1:0] add_chunk(input logic [MW-1:0] a);
    logic [MW:0] s;
    s = {1'b0, a} + (MW+1)'(CHUNK_MOD);
    if (s >= (MW+1)'(RING_BYTES)) begin
      s = s - (MW+1)'(RING_BYTES);
    end
    return MW'(s);
  endfunction

  // s == e counts as inside
  function automatic logic in_win(input logic [MW-1:0] p, input logic [MW-1:0] s,
                                  input logic [MW-1:0] e);
    if (s < e) begin
      return (p >= s) && (p < e);
    end
    return (p >= s) || (p < e);
  endfunction

  arrc_cmod #(.IN_W(CURSOR_W), .DIVISOR(RING_BYTES), .REM_W(MW)) u_play_mod (
    .num (item.play_cursor),
    .rem (play_m)
  );

  arrc_cmod #(.IN_W(CURSOR_W), .DIVISOR(RING_BYTES), .REM_W(MW)) u_wr_mod (
    .num (item.write_cursor),
    .rem (wr_m)
  );

  assign wr15 = CURSOR_W'(wr_m);

  arrc_cmod #(.IN_W(CURSOR_W), .DIVISOR(CHUNK_BYTES), .REM_W(CURSOR_W)) u_chunk_mod (
    .num (wr15),
    .rem (chunk_rem)
  );

  // marks rebuilt from the chunk holding the write cursor
  assign base_mark = MW'(wr15 - chunk_rem);
  assign trig_new  = add_chunk(base_mark);
  assign next_new  = add_chunk(trig_new);

  assign end_sum = SW'(last_fill_start_r) + SW'(item.bytes_read);

  arrc_cmod #(.IN_W(SW), .DIVISOR(RING_BYTES), .REM_W(MW)) u_end_mod (
    .num (end_sum),
    .rem (end_high)
  );

  always_comb begin
    source_mode_nxt     = source_mode_r;
    resync_pending_nxt  = resync_pending_r;
    valid_mark_nxt      = valid_mark_r;
    trigger_mark_nxt    = trigger_mark_r;
    next_write_mark_nxt = next_write_mark_r;
    latched_play_nxt    = latched_play_r;
    last_fill_start_nxt = last_fill_start_r;
    end_range_valid_nxt = end_range_valid_r;
    end_range_low_nxt   = end_range_low_r;
    end_range_high_nxt  = end_range_high_r;
    result              = '0;
    t_resync            = resync_pending_r | item.buffer_lost;
    t_data              = 1'b0;
    t_mode              = source_mode_r;
    t_erv               = end_range_valid_r;
    t_off               = '0;

    unique case (item.kind)
      KIND_TICK: begin
        latched_play_nxt = play_m;
        // a freshly started source skips the window checks
        priority if (source_mode_r == MODE_STARTED) begin
          result.rewind = 1'b1;
          t_resync      = 1'b1;
          t_mode        = MODE_ORPHANED;
        end else if (!in_win(wr_m, valid_mark_r, next_write_mark_r)) begin
          t_resync = 1'b1;
        end else if (in_win(wr_m, trigger_mark_r, next_write_mark_r)) begin
          t_data = 1'b1;
        end else begin
          t_data = 1'b0;
        end

        priority if (t_resync) begin
          t_erv              = 1'b0;
          t_off              = wr_m;
          result.fill_valid  = 1'b1;
          result.cross_fade  = 1'b1;
          result.fill_bytes  = CURSOR_W'(TWO_CHUNK - int'(chunk_rem));
        end else if (t_data) begin
          t_off              = next_write_mark_r;
          result.fill_valid  = 1'b1;
          result.fill_bytes  = CURSOR_W'(CHUNK_BYTES);
        end else begin
          t_off              = '0;
        end

        if (result.fill_valid) begin
          result.fill_offset  = CURSOR_W'(t_off);
          result.silence      = (t_mode == MODE_FREE);
          last_fill_start_nxt = t_off;
          valid_mark_nxt      = base_mark;
          trigger_mark_nxt    = trig_new;
          next_write_mark_nxt = next_new;
        end
        resync_pending_nxt = 1'b0;

        // stop test sees the range after this tick's resync
        if (t_mode != MODE_FREE && t_erv &&
            !in_win(play_m, end_range_low_r, end_range_high_r)) begin
          result.stopped = 1'b1;
          t_erv          = 1'b0;
        end
        source_mode_nxt     = t_mode;
        end_range_valid_nxt = t_erv;
      end
      KIND_ATTACH: begin
        source_mode_nxt    = MODE_STARTED;
        resync_pending_nxt = 1'b1;
      end
      KIND_DETACH: begin
        source_mode_nxt    = MODE_FREE;
        resync_pending_nxt = 1'b1;
      end
      KIND_UPDATE: begin
        if (source_mode_r != MODE_FREE) begin
          source_mode_nxt = MODE_UPDATED;
        end
      end
      KIND_FILL_DONE: begin
        if (source_mode_r != MODE_FREE && item.end_of_stream && !end_range_valid_r) begin
          end_range_valid_nxt = 1'b1;
          end_range_low_nxt   = latched_play_r;
          end_range_high_nxt  = end_high;
        end
      end
      default: begin
        source_mode_nxt = source_mode_r;
      end
    endcase

    result.source_state = source_mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_mode_r     <= MODE_FREE;
      resync_pending_r  <= 1'b0;
      valid_mark_r      <= '0;
      trigger_mark_r    <= '0;
      next_write_mark_r <= '0;
      latched_play_r    <= '0;
      last_fill_start_r <= '0;
      end_range_valid_r <= 1'b0;
      end_range_low_r   <= '0;
      end_range_high_r  <= '0;
    end else if (advance) begin
      source_mode_r     <= source_mode_nxt;
      resync_pending_r  <= resync_pending_nxt;
      valid_mark_r      <= valid_mark_nxt;
      trigger_mark_r    <= trigger_mark_nxt;
      next_write_mark_r <= next_write_mark_nxt;
      latched_play_r    <= latched_play_nxt;
      last_fill_start_r <= last_fill_start_nxt;
      end_range_valid_r <= end_range_valid_nxt;
      end_range_low_r   <= end_range_low_nxt;
      end_range_high_r  <= end_range_high_nxt;
    end
  end

endmodule

// ===== hw/rtl/audio_ring_refill_controller_core.sv =====
// Audio ring refill controller, top level: input register, event engine, result register.
// An accepted transaction waits in the input register; out_* shows its registered result.
// Throughput: one transaction per cycle, single event step; out_ready low can stall it.
// Reset: synchronous, active low; clears both stages and all source and mark state.
// Depends on arrc_pkg, arrc_step, arrc_cmod and the assertion macro header.
`include "audio_ring_refill_controller_core_defines.svh"

module audio_ring_refill_controller_core #(
  parameter int RING_BYTES  = 32768,
  parameter int CHUNK_BYTES = 8192
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [14:0] in_play_cursor,
  input  logic [14:0] in_write_cursor,
  input  logic        in_buffer_lost,
  input  logic [14:0] in_bytes_read,
  input  logic        in_end_of_stream,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_fill_valid,
  output logic [14:0] out_fill_offset,
  output logic [14:0] out_fill_bytes,
  output logic        out_cross_fade,
  output logic        out_silence,
  output logic        out_rewind,
  output logic        out_stopped,
  output logic [1:0]  out_source_state
);
  import arrc_pkg::*;

  item_t s1_item_r, s1_item_nxt;
  logic  s1_valid_r, s1_valid_nxt;
  res_t  out_res_r;
  logic  out_valid_r, out_valid_nxt;
  res_t  step_res;
  logic  s1_adv;
  logic  in_take;

  // stage one moves on when the result register is empty or being drained
  assign s1_adv   = s1_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~s1_valid_r | s1_adv;
  assign in_take  = in_valid & in_ready;

  always_comb begin
    s1_item_nxt.kind          = in_kind;
    s1_item_nxt.play_cursor   = in_play_cursor;
    s1_item_nxt.write_cursor  = in_write_cursor;
    s1_item_nxt.buffer_lost   = in_buffer_lost;
    s1_item_nxt.bytes_read    = in_bytes_read;
    s1_item_nxt.end_of_stream = in_end_of_stream;
  end

  assign s1_valid_nxt  = in_take | (s1_valid_r & ~s1_adv);
  assign out_valid_nxt = s1_adv | (out_valid_r & ~out_ready);

  arrc_step #(.RING_BYTES(RING_BYTES), .CHUNK_BYTES(CHUNK_BYTES)) u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (s1_adv),
    .item    (s1_item_r),
    .result  (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= s1_item_nxt;
    end
    if (s1_adv) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_fill_valid   = out_res_r.fill_valid;
  assign out_fill_offset  = out_res_r.fill_offset;
  assign out_fill_bytes   = out_res_r.fill_bytes;
  assign out_cross_fade   = out_res_r.cross_fade;
  assign out_silence      = out_res_r.silence;
  assign out_rewind       = out_res_r.rewind;
  assign out_stopped      = out_res_r.stopped;
  assign out_source_state = out_res_r.source_state;

  `ARRC_ASSERT_SAME(a_no_fill_zero, out_valid_r && !out_res_r.fill_valid, (out_res_r.fill_offset == 15'd0) && (out_res_r.fill_bytes == 15'd0) && !out_res_r.cross_fade && !out_res_r.silence, "fill fields set without a fill")
  `ARRC_ASSERT_SAME(a_rewind_resync, out_valid_r && out_res_r.rewind, out_res_r.cross_fade && out_res_r.fill_valid && (out_res_r.source_state == MODE_ORPHANED), "rewind without resync fill")
  `ARRC_ASSERT_SAME(a_stop_no_resync, out_valid_r && out_res_r.stopped, !out_res_r.cross_fade, "stop reported on a resync tick")
  `ARRC_ASSERT_NEXT(a_s1_drains, s1_valid_r && !out_valid_r, out_valid_r, "held transaction not moved to result register")

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for audio_ring_refill_controller_core: directed events, random traffic,
// idle and back-pressure phases, each result checked against a predictor of the refill logic.
// Depends on arrc_pkg and the controller RTL.
`timescale 1ns / 100ps

module testbench;
  import arrc_pkg::*;

  localparam int RING         = 32768;
  localparam int CHUNK        = 8192;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;

  localparam logic [2:0] KIND_RSVD_FIRST = 3'd5;
  localparam logic [2:0] KIND_RSVD_LAST  = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_kind;
  logic [14:0] in_play_cursor;
  logic [14:0] in_write_cursor;
  logic        in_buffer_lost;
  logic [14:0] in_bytes_read;
  logic        in_end_of_stream;
  logic        out_valid;
  logic        out_ready;
  logic        out_fill_valid;
  logic [14:0] out_fill_offset;
  logic [14:0] out_fill_bytes;
  logic        out_cross_fade;
  logic        out_silence;
  logic        out_rewind;
  logic        out_stopped;
  logic [1:0]  out_source_state;

  audio_ring_refill_controller_core #(
    .RING_BYTES (RING),
    .CHUNK_BYTES(CHUNK)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_play_cursor  (in_play_cursor),
    .in_write_cursor (in_write_cursor),
    .in_buffer_lost  (in_buffer_lost),
    .in_bytes_read   (in_bytes_read),
    .in_end_of_stream(in_end_of_stream),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_fill_valid  (out_fill_valid),
    .out_fill_offset (out_fill_offset),
    .out_fill_bytes  (out_fill_bytes),
    .out_cross_fade  (out_cross_fade),
    .out_silence     (out_silence),
    .out_rewind      (out_rewind),
    .out_stopped     (out_stopped),
    .out_source_state(out_source_state)
  );

  int   err_count      = 0;
  int   sender_idle_pct = 0;
  int   recv_stall_pct  = 0;
  int   hold_request    = 0;
  res_t pending_res[$];

  // traffic generator's notion of where the write cursor is
  int unsigned cur_write = 0;

  // predictor state
  logic [1:0]  p_mode       = MODE_FREE;
  bit          p_resync     = 1'b0;
  int unsigned p_valid_mark = 0;
  int unsigned p_trig_mark  = 0;
  int unsigned p_next_mark  = 0;
  int unsigned p_play_latch = 0;
  int unsigned p_fill_start = 0;
  bit          p_end_armed  = 1'b0;
  int unsigned p_end_lo     = 0;
  int unsigned p_end_hi     = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // wrap-around window: equal ends cover the whole ring
  function automatic bit ring_window(int unsigned p, int unsigned s, int unsigned e);
    if (s < e) return (p >= s) && (p < e);
    return (p >= s) || (p < e);
  endfunction

  function automatic res_t predict_refill_step(item_t it);
    res_t        r;
    int unsigned play;
    int unsigned wr;
    int unsigned off;
    int unsigned nb;
    bit          resync;
    bit          chunk_due;
    r = '0;
    case (it.kind)
      KIND_TICK: begin
        play      = it.play_cursor % RING;
        wr        = it.write_cursor % RING;
        resync    = p_resync || it.buffer_lost;
        chunk_due = 1'b0;
        off       = 0;
        nb        = 0;
        p_play_latch = play;
        if (p_mode == MODE_STARTED) begin
          r.rewind = 1'b1;
          resync   = 1'b1;
          p_mode   = MODE_ORPHANED;
        end else if (!ring_window(wr, p_valid_mark, p_next_mark)) begin
          resync = 1'b1;
        end else if (ring_window(wr, p_trig_mark, p_next_mark)) begin
          chunk_due = 1'b1;
        end
        if (resync) begin
          p_end_armed  = 1'b0;
          r.fill_valid = 1'b1;
          r.cross_fade = 1'b1;
          off = wr;
          nb  = 2 * CHUNK - (wr % CHUNK);
        end else if (chunk_due) begin
          r.fill_valid = 1'b1;
          off = p_next_mark;
          nb  = CHUNK;
        end
        if (r.fill_valid) begin
          r.fill_offset = off[CURSOR_W-1:0];
          r.fill_bytes  = nb[CURSOR_W-1:0];
          r.silence     = (p_mode == MODE_FREE);
          p_fill_start  = off;
          p_valid_mark  = ((wr / CHUNK) * CHUNK) % RING;
          p_trig_mark   = (p_valid_mark + CHUNK) % RING;
          p_next_mark   = (p_trig_mark + CHUNK) % RING;
        end
        p_resync = 1'b0;
        // evaluated after the fill decision, so a resync has already disarmed it
        if (p_mode != MODE_FREE && p_end_armed && !ring_window(play, p_end_lo, p_end_hi)) begin
          r.stopped   = 1'b1;
          p_end_armed = 1'b0;
        end
      end
      KIND_ATTACH: begin
        p_mode   = MODE_STARTED;
        p_resync = 1'b1;
      end
      KIND_DETACH: begin
        p_mode   = MODE_FREE;
        p_resync = 1'b1;
      end
      KIND_UPDATE: begin
        if (p_mode != MODE_FREE) p_mode = MODE_UPDATED;
      end
      KIND_FILL_DONE: begin
        if (p_mode != MODE_FREE && it.end_of_stream && !p_end_armed) begin
          p_end_armed = 1'b1;
          p_end_lo    = p_play_latch;
          p_end_hi    = (p_fill_start + it.bytes_read) % RING;
        end
      end
      default: ;
    endcase
    r.source_state = p_mode;
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      err_count++;
    end
  endfunction

  // result checking first, then prediction for a newly accepted transaction
  always @(posedge clk) begin : scoreboard
    res_t  got;
    res_t  want;
    item_t acc;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = {out_fill_valid, out_fill_offset, out_fill_bytes, out_cross_fade,
               out_silence, out_rewind, out_stopped, out_source_state};
        if (pending_res.size() == 0) begin
          $display("%0t: result with no transaction outstanding, actual %0h", $time, got);
          err_count++;
        end else begin
          want = pending_res.pop_front();
          check_field("fill_valid", want.fill_valid, got.fill_valid);
          check_field("fill_offset", want.fill_offset, got.fill_offset);
          check_field("fill_bytes", want.fill_bytes, got.fill_bytes);
          check_field("cross_fade", want.cross_fade, got.cross_fade);
          check_field("silence", want.silence, got.silence);
          check_field("rewind", want.rewind, got.rewind);
          check_field("stopped", want.stopped, got.stopped);
          check_field("source_state", want.source_state, got.source_state);
        end
      end
      if (in_valid && in_ready) begin
        acc = {in_kind, in_play_cursor, in_write_cursor, in_buffer_lost,
               in_bytes_read, in_end_of_stream};
        pending_res.push_back(predict_refill_step(acc));
      end
    end
  end

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  function automatic item_t mk_item(logic [2:0] kind, int unsigned play, int unsigned wr,
                                    bit lost, int unsigned br, bit eos);
    item_t it;
    it.kind          = kind;
    it.play_cursor   = play[CURSOR_W-1:0];
    it.write_cursor  = wr[CURSOR_W-1:0];
    it.buffer_lost   = lost;
    it.bytes_read    = br[CURSOR_W-1:0];
    it.end_of_stream = eos;
    return it;
  endfunction

  // valid stays high into the next transaction unless a gap is drawn
  task automatic send_item(item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= it.kind;
    in_play_cursor   <= it.play_cursor;
    in_write_cursor  <= it.write_cursor;
    in_buffer_lost   <= it.buffer_lost;
    in_bytes_read    <= it.bytes_read;
    in_end_of_stream <= it.end_of_stream;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
  endtask

  // mostly plausible event streams with the write cursor creeping round the ring
  function automatic item_t next_traffic_item();
    item_t       it;
    int unsigned sel;
    it = mk_item($urandom_range(KIND_RSVD_LAST, KIND_TICK), $urandom, $urandom,
                 $urandom_range(1), $urandom, $urandom_range(1));
    if ($urandom_range(99) < 20) return it;
    sel = $urandom_range(99);
    if (sel < 60) begin
      it.kind = KIND_TICK;
      if ($urandom_range(99) < 5) cur_write = $urandom_range(RING - 1);
      else cur_write = (cur_write + $urandom_range(CHUNK / 2)) % RING;
      it.write_cursor = cur_write[CURSOR_W-1:0];
      it.play_cursor  = CURSOR_W'((cur_write + RING - $urandom_range(CHUNK)) % RING);
      it.buffer_lost  = ($urandom_range(99) < 3);
    end else if (sel < 68) begin
      it.kind = KIND_ATTACH;
    end else if (sel < 73) begin
      it.kind = KIND_DETACH;
    end else if (sel < 80) begin
      it.kind = KIND_UPDATE;
    end else begin
      it.kind       = KIND_FILL_DONE;
      it.bytes_read = CURSOR_W'($urandom_range(2 * CHUNK));
    end
    return it;
  endfunction

  task automatic run_random_traffic(int n_items);
    item_t it;
    int    sent;
    sent = 0;
    while (sent < n_items) begin
      it = next_traffic_item();
      send_item(it);
      if (it.kind <= KIND_FILL_DONE) sent++;
    end
  endtask

  task automatic test_idle_source();
    // marks all zero after reset, so the whole ring is one window
    send_item(mk_item(KIND_TICK, 0, 0, 0, 0, 0));
    send_item(mk_item(KIND_UPDATE, 0, 0, 0, 0, 0));
    send_item(mk_item(KIND_FILL_DONE, 0, 0, 0, 2 * CHUNK, 1));
    for (int k = KIND_RSVD_FIRST; k <= KIND_RSVD_LAST; k++)
      send_item(mk_item(k[2:0], RING - 1, RING - 1, 1, RING - 1, 1));
    send_item(mk_item(KIND_TICK, RING - 1, RING - 1, 1, 0, 0));
  endtask

  task automatic test_source_lifecycle();
    send_item(mk_item(KIND_ATTACH, 0, 0, 0, 0, 0));
    send_item(mk_item(KIND_ATTACH, 0, 0, 0, 0, 0));
    send_item(mk_item(KIND_TICK, 50, 100, 0, 0, 0));
    send_item(mk_item(KIND_UPDATE, 0, 0, 0, 0, 0));
    send_item(mk_item(KIND_FILL_DONE, 0, 0, 0, 1000, 1));
    send_item(mk_item(KIND_TICK, 2000, 200, 0, 0, 0));
    send_item(mk_item(KIND_TICK, 3000, CHUNK, 0, 0, 0));
    send_item(mk_item(KIND_FILL_DONE, 0, 0, 0, RING - 1, 1));
    // play out of range, but the resync on the same tick disarms the stop
    send_item(mk_item(KIND_TICK, 20000, 100, 0, 0, 0));
    send_item(mk_item(KIND_FILL_DONE, 0, 0, 0, 100, 0));
    send_item(mk_item(KIND_TICK, 0, RING - 1, 1, 0, 0));
    send_item(mk_item(KIND_DETACH, 0, 0, 0, 0, 0));
    send_item(mk_item(KIND_TICK, 0, 0, 0, 0, 0));
    send_item(mk_item(KIND_FILL_DONE, 0, 0, 0, 500, 1));
    send_item(mk_item(KIND_ATTACH, 0, 0, 0, 0, 0));
    send_item(mk_item(KIND_UPDATE, 0, 0, 0, 0, 0));
    send_item(mk_item(KIND_TICK, 100, 2 * CHUNK - 1, 0, 0, 0));
  endtask

  task automatic test_random_phases();
    int send_pct[4];
    int stall_pct[4];
    send_pct  = '{0, 80, 0, 38};
    stall_pct = '{0, 0, 80, 38};
    for (int i = 0; i < 4; i++) begin
      sender_idle_pct = send_pct[i];
      recv_stall_pct  = stall_pct[i];
      run_random_traffic(115);
    end
  endtask

  task automatic test_backpressure();
    wait_drained();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_request    = HOLD_CYCLES;
    run_random_traffic(30);
    // sender holds off until every transaction has produced its result
    wait_drained();
    run_random_traffic(10);
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_kind          <= KIND_TICK;
    in_play_cursor   <= '0;
    in_write_cursor  <= '0;
    in_buffer_lost   <= 1'b0;
    in_bytes_read    <= '0;
    in_end_of_stream <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_source();
    test_source_lifecycle();
    test_random_phases();
    test_backpressure();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_res.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
